// ===== src/ail_pkg.sv =====
// shared constants, codes and types for the active interval lookup
package ail_pkg;

	localparam int DEPTH = 256;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DW    = 32;
	localparam int TW    = DW + 2;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_QUERY = 2'd1,
		OP_SEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic          shift;
		logic [DW-1:0] wrap_start;
		logic [DW-1:0] wrap_end;
	} ring_ctl_t;

endpackage

// ===== src/ail_cell.sv =====
// one table cell of the rotating interval ring
module ail_cell (
	input  logic                     clk,
	input  logic                     shift,
	input  logic [ail_pkg::DW-1:0]   d_start,
	input  logic [ail_pkg::DW-1:0]   d_end,
	output logic [ail_pkg::DW-1:0]   q_start,
	output logic [ail_pkg::DW-1:0]   q_end
);

	logic [ail_pkg::DW-1:0] start_q;
	logic [ail_pkg::DW-1:0] end_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			start_q <= d_start;
			end_q   <= d_end;
		end
	end

	assign q_start = start_q;
	assign q_end   = end_q;

endmodule

// ===== src/ail_ctrl.sv =====
// sequencer and head-of-ring compare for add, query, seek and clear
module ail_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [ail_pkg::DW-1:0]        start_ms,
	input  logic [ail_pkg::DW-1:0]        end_ms,
	input  logic [ail_pkg::DW-1:0]        clock_ms,
	input  logic [ail_pkg::DW-1:0]        offset,
	input  logic [ail_pkg::DW-1:0]        head_start,
	input  logic [ail_pkg::DW-1:0]        head_end,
	output ail_pkg::ring_ctl_t            ring,
	output logic                          done,
	output logic [1:0]                    status,
	output logic                          found,
	output logic [7:0]                    entry_index,
	output logic [ail_pkg::DW-1:0]        entry_start,
	output logic [ail_pkg::DW-1:0]        entry_end
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                          state_q;
	ail_pkg::op_t                    op_q;
	logic signed [ail_pkg::TW-1:0]   t_q;
	logic [ail_pkg::IDX_W-1:0]       first_q;
	logic [ail_pkg::IDX_W-1:0]       k_q;
	logic [ail_pkg::CNT_W-1:0]       count_q;
	logic [ail_pkg::IDX_W-1:0]       hint_q;
	logic [ail_pkg::DW-1:0]          add_start_q;
	logic [ail_pkg::DW-1:0]          add_end_q;
	logic                            p1_done_q;
	logic                            p1_hit_q;
	logic [ail_pkg::IDX_W-1:0]       p1_pos_q;
	logic [ail_pkg::DW-1:0]          p1_s_q;
	logic [ail_pkg::DW-1:0]          p1_e_q;
	logic                            p2_done_q;
	logic                            p2_hit_q;
	logic [ail_pkg::IDX_W-1:0]       p2_pos_q;
	logic [ail_pkg::DW-1:0]          p2_s_q;
	logic [ail_pkg::DW-1:0]          p2_e_q;
	logic                            done_q;
	ail_pkg::status_t                status_q;
	logic                            found_q;
	logic [7:0]                      idx_q;
	logic [ail_pkg::DW-1:0]          es_q;
	logic [ail_pkg::DW-1:0]          ee_q;

	logic signed [ail_pkg::TW-1:0]   t_in;
	logic signed [ail_pkg::TW-1:0]   hs;
	logic signed [ail_pkg::TW-1:0]   he;
	logic                            in_range;
	logic                            contains;
	logic                            after;
	logic                            insert;
	ail_pkg::op_t                    op_in;
	ail_pkg::status_t                add_status;

	assign op_in    = ail_pkg::op_t'(op);
	assign t_in     = $signed({2'b00, clock_ms})
		+ $signed({{2{offset[ail_pkg::DW-1]}}, offset});
	assign hs       = $signed({2'b00, head_start});
	assign he       = $signed({2'b00, head_end});
	assign in_range = {1'b0, k_q} < count_q;
	assign contains = (hs <= t_q) && (t_q <= he);
	assign after    = hs > t_q;
	assign insert   = (op_q == ail_pkg::OP_ADD) && ({1'b0, k_q} == count_q);

	always_comb begin
		if (end_ms <= start_ms) begin
			add_status = ail_pkg::STAT_BAD;
		end else if (count_q == ail_pkg::CNT_W'(ail_pkg::DEPTH)) begin
			add_status = ail_pkg::STAT_FULL;
		end else begin
			add_status = ail_pkg::STAT_OK;
		end
	end

	always_comb begin
		ring.shift      = state_q == ST_SCAN;
		ring.wrap_start = insert ? add_start_q : head_start;
		ring.wrap_end   = insert ? add_end_q : head_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= ail_pkg::OP_ADD;
			t_q         <= '0;
			first_q     <= '0;
			k_q         <= '0;
			count_q     <= '0;
			hint_q      <= '0;
			add_start_q <= '0;
			add_end_q   <= '0;
			p1_done_q   <= 1'b0;
			p1_hit_q    <= 1'b0;
			p1_pos_q    <= '0;
			p1_s_q      <= '0;
			p1_e_q      <= '0;
			p2_done_q   <= 1'b0;
			p2_hit_q    <= 1'b0;
			p2_pos_q    <= '0;
			p2_s_q      <= '0;
			p2_e_q      <= '0;
			done_q      <= 1'b0;
			status_q    <= ail_pkg::STAT_OK;
			found_q     <= 1'b0;
			idx_q       <= '0;
			es_q        <= '0;
			ee_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q        <= op_in;
						t_q         <= t_in;
						add_start_q <= start_ms;
						add_end_q   <= end_ms;
						k_q         <= '0;
						p1_done_q   <= 1'b0;
						p1_hit_q    <= 1'b0;
						p1_pos_q    <= '0;
						p2_done_q   <= 1'b0;
						p2_hit_q    <= 1'b0;
						first_q     <= ({1'b0, hint_q} < count_q) ? hint_q : '0;
						found_q     <= 1'b0;
						idx_q       <= '0;
						es_q        <= '0;
						ee_q        <= '0;
						status_q    <= (op_in == ail_pkg::OP_ADD) ? add_status
							: ail_pkg::STAT_OK;
						done_q      <= (op_in == ail_pkg::OP_CLEAR)
							|| (op_in == ail_pkg::OP_ADD && add_status != ail_pkg::STAT_OK);
						case (op_in)
							ail_pkg::OP_ADD: begin
								if (add_status == ail_pkg::STAT_OK) begin
									state_q <= ST_SCAN;
								end
							end
							ail_pkg::OP_CLEAR: begin
								count_q <= '0;
								hint_q  <= '0;
							end
							default: begin
								state_q <= ST_SCAN;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					done_q <= 1'b0;
					k_q <= k_q + 1'b1;
					if (k_q == ail_pkg::IDX_W'(ail_pkg::DEPTH - 1)) begin
						state_q <= ST_FIN;
					end
					if (in_range && op_q == ail_pkg::OP_QUERY) begin
						if (k_q >= first_q) begin
							if (!p1_done_q && contains) begin
								p1_done_q <= 1'b1;
								p1_hit_q  <= 1'b1;
								p1_pos_q  <= k_q;
								p1_s_q    <= head_start;
								p1_e_q    <= head_end;
							end else if (!p1_done_q && after) begin
								p1_done_q <= 1'b1;
							end
						end else begin
							if (!p2_done_q && contains) begin
								p2_done_q <= 1'b1;
								p2_hit_q  <= 1'b1;
								p2_pos_q  <= k_q;
								p2_s_q    <= head_start;
								p2_e_q    <= head_end;
							end else if (!p2_done_q && after) begin
								p2_done_q <= 1'b1;
							end
						end
					end
					if (in_range && op_q == ail_pkg::OP_SEEK && !p1_done_q && after) begin
						p1_done_q <= 1'b1;
						p1_pos_q  <= (k_q == '0) ? '0 : k_q - 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					case (op_q)
						ail_pkg::OP_ADD: begin
							count_q <= count_q + 1'b1;
						end
						ail_pkg::OP_QUERY: begin
							if (p1_hit_q) begin
								hint_q  <= p1_pos_q;
								found_q <= 1'b1;
								idx_q   <= 8'(p1_pos_q);
								es_q    <= p1_s_q;
								ee_q    <= p1_e_q;
							end else if (p2_hit_q) begin
								hint_q  <= p2_pos_q;
								found_q <= 1'b1;
								idx_q   <= 8'(p2_pos_q);
								es_q    <= p2_s_q;
								ee_q    <= p2_e_q;
							end
						end
						ail_pkg::OP_SEEK: begin
							hint_q <= p1_done_q ? p1_pos_q : '0;
						end
						default: begin
							hint_q <= hint_q;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_index = idx_q;
	assign entry_start = es_q;
	assign entry_end   = ee_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ail_pkg::CNT_W'(ail_pkg::DEPTH))
		else $error("entry count past table depth");

	a_hint_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hint_q == '0 || {1'b0, hint_q} < count_q)
		else $error("hint outside filled table");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == ail_pkg::OP_CLEAR |=> count_q == '0 && done_q)
		else $error("clear did not empty table");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> done_q && state_q == ST_IDLE)
		else $error("scan end without result");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && found_q |-> status_q == ail_pkg::STAT_OK && op_q == ail_pkg::OP_QUERY)
		else $error("hit reported outside a query");
`endif

endmodule

// ===== src/active_interval_lookup.sv =====
// top level: interval table held in a rotating ring of cells with a search hint
//
//  channel   direction  handshake               payload
//  command   in         start, busy             op, start_ms, end_ms, clock_ms
//  config    in         cfg_valid, cfg_ready    cfg_data (time offset, signed)
//  result    out        done (one-cycle strobe) status, found, entry_index,
//                                               entry_start, entry_end
//
// add (accepted), query and seek rotate the whole ring once, one cell per cycle
// past the compare at its head; the finish state then registers the result strobe
// clear and rejected adds answer in the cycle after the transfer
// busy is high while the ring turns and in the finish state; a new command is taken in the strobe cycle
// arst_n empties the table, zeroes the hint and the offset; results cannot stall
module active_interval_lookup (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               op,
	input  logic [ail_pkg::DW-1:0]   start_ms,
	input  logic [ail_pkg::DW-1:0]   end_ms,
	input  logic [ail_pkg::DW-1:0]   clock_ms,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [ail_pkg::DW-1:0]   cfg_data,
	output logic                     done,
	output logic [1:0]               status,
	output logic                     found,
	output logic [7:0]               entry_index,
	output logic [ail_pkg::DW-1:0]   entry_start,
	output logic [ail_pkg::DW-1:0]   entry_end
);

	logic [ail_pkg::DW-1:0] offset_q;
	logic [ail_pkg::DW-1:0] cell_start [ail_pkg::DEPTH];
	logic [ail_pkg::DW-1:0] cell_end   [ail_pkg::DEPTH];
	ail_pkg::ring_ctl_t     ring;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	for (genvar i = 0; i < ail_pkg::DEPTH; i++) begin : g_ring
		if (i == ail_pkg::DEPTH - 1) begin : g_tail
			ail_cell u_cell (
				.clk     (clk),
				.shift   (ring.shift),
				.d_start (ring.wrap_start),
				.d_end   (ring.wrap_end),
				.q_start (cell_start[i]),
				.q_end   (cell_end[i])
			);
		end else begin : g_body
			ail_cell u_cell (
				.clk     (clk),
				.shift   (ring.shift),
				.d_start (cell_start[i+1]),
				.d_end   (cell_end[i+1]),
				.q_start (cell_start[i]),
				.q_end   (cell_end[i])
			);
		end
	end

	ail_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.start_ms    (start_ms),
		.end_ms      (end_ms),
		.clock_ms    (clock_ms),
		.offset      (offset_q),
		.head_start  (cell_start[0]),
		.head_end    (cell_end[0]),
		.ring        (ring),
		.done        (done),
		.status      (status),
		.found       (found),
		.entry_index (entry_index),
		.entry_start (entry_start),
		.entry_end   (entry_end)
	);

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for active_interval_lookup: directed tests, then random phases
module testbench;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = ail_pkg::DEPTH + 40;

	typedef struct {
		ail_pkg::status_t       status;
		logic                   found;
		logic [7:0]             entry_idx;
		logic [ail_pkg::DW-1:0] entry_lo;
		logic [ail_pkg::DW-1:0] entry_hi;
	} lookup_answer_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [1:0]             op;
	logic [ail_pkg::DW-1:0] start_ms;
	logic [ail_pkg::DW-1:0] end_ms;
	logic [ail_pkg::DW-1:0] clock_ms;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [ail_pkg::DW-1:0] cfg_data;
	logic                   done;
	logic [1:0]             status;
	logic                   found;
	logic [7:0]             entry_index;
	logic [ail_pkg::DW-1:0] entry_start;
	logic [ail_pkg::DW-1:0] entry_end;

	// table model
	logic [ail_pkg::DW-1:0]        tab_start [ail_pkg::DEPTH];
	logic [ail_pkg::DW-1:0]        tab_end [ail_pkg::DEPTH];
	int                            entry_cnt;
	int                            hint_pos;
	logic signed [ail_pkg::DW-1:0] offset_model;

	lookup_answer_t answer_q[$];
	int             error_count;
	int             cmd_count;
	int             stall_cycles;
	int             sender_idle_pct;

	active_interval_lookup dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.start_ms    (start_ms),
		.end_ms      (end_ms),
		.clock_ms    (clock_ms),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.found       (found),
		.entry_index (entry_index),
		.entry_start (entry_start),
		.entry_end   (entry_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint shifted_clock(logic [ail_pkg::DW-1:0] c_in);
		return longint'(c_in) + longint'(offset_model);
	endfunction

	function automatic bit scan_span(int from, int upto, longint t, output int pos);
		longint s;
		longint e;
		pos = 0;
		for (int i = from; i < upto; i++) begin
			s = longint'(tab_start[i]);
			e = longint'(tab_end[i]);
			if (s <= t && t <= e) begin
				pos = i;
				return 1'b1;
			end
			if (s > t)
				return 1'b0;
		end
		return 1'b0;
	endfunction

	function automatic lookup_answer_t apply_command(ail_pkg::op_t cmd,
			logic [ail_pkg::DW-1:0] s_in, logic [ail_pkg::DW-1:0] e_in,
			logic [ail_pkg::DW-1:0] c_in);
		lookup_answer_t a;
		longint t;
		int origin;
		int pos;
		bit hit;
		bit stopped;
		a.status = ail_pkg::STAT_OK;
		a.found = 1'b0;
		a.entry_idx = '0;
		a.entry_lo = '0;
		a.entry_hi = '0;
		case (cmd)
			ail_pkg::OP_ADD: begin
				if (e_in <= s_in)
					a.status = ail_pkg::STAT_BAD;
				else if (entry_cnt >= ail_pkg::DEPTH)
					a.status = ail_pkg::STAT_FULL;
				else begin
					tab_start[entry_cnt] = s_in;
					tab_end[entry_cnt] = e_in;
					entry_cnt++;
				end
			end
			ail_pkg::OP_QUERY: begin
				if (entry_cnt > 0) begin
					t = shifted_clock(c_in);
					origin = (hint_pos < entry_cnt) ? hint_pos : 0;
					hit = scan_span(origin, entry_cnt, t, pos);
					if (!hit)
						hit = scan_span(0, origin, t, pos);
					if (hit) begin
						hint_pos = pos;
						a.found = 1'b1;
						a.entry_idx = pos[7:0];
						a.entry_lo = tab_start[pos];
						a.entry_hi = tab_end[pos];
					end
				end
			end
			ail_pkg::OP_SEEK: begin
				t = shifted_clock(c_in);
				hint_pos = 0;
				stopped = 1'b0;
				for (int i = 0; i < entry_cnt; i++) begin
					if (!stopped && longint'(tab_start[i]) > t) begin
						hint_pos = (i > 0) ? i - 1 : 0;
						stopped = 1'b1;
					end
				end
			end
			default: begin
				entry_cnt = 0;
				hint_pos = 0;
			end
		endcase
		return a;
	endfunction

	task automatic send_command(ail_pkg::op_t cmd, logic [ail_pkg::DW-1:0] s_in,
			logic [ail_pkg::DW-1:0] e_in, logic [ail_pkg::DW-1:0] c_in);
		@(negedge clk);
		op = cmd;
		start_ms = s_in;
		end_ms = e_in;
		clock_ms = c_in;
		start = ($urandom_range(0, 99) >= sender_idle_pct);
		@(posedge clk);
		while (!(start && busy === 1'b0)) begin
			@(negedge clk);
			start = ($urandom_range(0, 99) >= sender_idle_pct);
			@(posedge clk);
		end
		answer_q.push_back(apply_command(cmd, s_in, e_in, c_in));
		cmd_count++;
	endtask

	task automatic drain_results(int extra_cycles);
		@(negedge clk);
		start = 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (extra_cycles) @(posedge clk);
	endtask

	task automatic write_offset(logic [ail_pkg::DW-1:0] value);
		drain_results(8);
		@(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		offset_model = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic check_field(string name, logic [ail_pkg::DW-1:0] want,
			logic [ail_pkg::DW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		lookup_answer_t a;
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (done === 1'b1) begin
				if (answer_q.size() == 0) begin
					$display("%0t: result with nothing expected, actual status %0h", $time, status);
					error_count++;
				end else begin
					a = answer_q.pop_front();
					check_field("status", a.status, status);
					check_field("found", a.found, found);
					check_field("entry_index", a.entry_idx, entry_index);
					check_field("entry_start", a.entry_lo, entry_start);
					check_field("entry_end", a.entry_hi, entry_end);
				end
			end
		end
	end

	task automatic test_empty_table();
		send_command(ail_pkg::OP_QUERY, '0, '0, '0);
		send_command(ail_pkg::OP_SEEK, '0, '0, '1);
		send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
	endtask

	task automatic test_bad_interval();
		send_command(ail_pkg::OP_ADD, 32'd100, 32'd100, '0);
		send_command(ail_pkg::OP_ADD, '1, '0, '0);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd100);
	endtask

	task automatic test_hint_search();
		send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
		send_command(ail_pkg::OP_ADD, 32'd10, 32'd20, '0);
		send_command(ail_pkg::OP_ADD, 32'd30, 32'd40, '0);
		send_command(ail_pkg::OP_ADD, 32'd50, 32'd60, '0);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd60);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd10);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd25);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd61);
	endtask

	task automatic test_seek();
		send_command(ail_pkg::OP_SEEK, '0, '0, 32'd35);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd35);
		send_command(ail_pkg::OP_SEEK, '0, '0, 32'd5);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd55);
		send_command(ail_pkg::OP_SEEK, '0, '0, 32'd1000);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd20);
	endtask

	task automatic test_offset_extremes();
		send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
		send_command(ail_pkg::OP_ADD, '0, '1, '0);
		write_offset(32'h8000_0000);
		send_command(ail_pkg::OP_QUERY, '0, '0, '0);
		send_command(ail_pkg::OP_QUERY, '0, '0, '1);
		send_command(ail_pkg::OP_SEEK, '0, '0, '0);
		write_offset(32'h7fff_ffff);
		send_command(ail_pkg::OP_QUERY, '0, '0, '0);
		send_command(ail_pkg::OP_QUERY, '0, '0, '1);
		send_command(ail_pkg::OP_SEEK, '0, '0, '1);
		write_offset('0);
	endtask

	task automatic test_full_table();
		send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
		for (int i = 0; i < ail_pkg::DEPTH; i++)
			send_command(ail_pkg::OP_ADD, i * 16, i * 16 + 7, '0);
		send_command(ail_pkg::OP_ADD, 32'd1, 32'd2, '0);
		send_command(ail_pkg::OP_ADD, 32'd5, 32'd5, '0);
		send_command(ail_pkg::OP_QUERY, '0, '0, (ail_pkg::DEPTH - 1) * 16 + 3);
		send_command(ail_pkg::OP_QUERY, '0, '0, 32'd5);
		send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
	endtask

	function automatic logic [ail_pkg::DW-1:0] near_entry_clock();
		logic [ail_pkg::DW-1:0] target;
		int i;
		if (entry_cnt == 0)
			return $urandom;
		i = $urandom_range(0, entry_cnt - 1);
		case ($urandom_range(0, 4))
			0: target = tab_start[i];
			1: target = tab_end[i];
			2: target = tab_start[i] - 1;
			3: target = tab_end[i] + 1;
			default: target = tab_start[i] + $urandom_range(0, tab_end[i] - tab_start[i]);
		endcase
		return target - offset_model;
	endfunction

	task automatic test_random(int items, int idle_pct);
		int target;
		int pick;
		logic [ail_pkg::DW-1:0] edge_ms;
		logic [ail_pkg::DW-1:0] lo;
		logic [ail_pkg::DW-1:0] hi;
		sender_idle_pct = idle_pct;
		target = cmd_count + items;
		while (cmd_count < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
			else if (pick < 75) begin
				if ($urandom_range(0, 3) != 0)
					send_command(ail_pkg::OP_CLEAR, '0, '0, '0);
				edge_ms = $urandom_range(0, 32'hffff_0000);
				repeat ($urandom_range(1, 12)) begin
					lo = edge_ms + $urandom_range(0, 1000);
					hi = lo + $urandom_range(1, 500);
					if ($urandom_range(0, 9) == 0)
						hi = lo;
					send_command(ail_pkg::OP_ADD, lo, hi, $urandom);
					edge_ms = hi;
				end
				repeat ($urandom_range(2, 10)) begin
					if ($urandom_range(0, 9) < 6)
						send_command(ail_pkg::OP_QUERY, $urandom, $urandom, near_entry_clock());
					else
						send_command(ail_pkg::OP_SEEK, $urandom, $urandom, near_entry_clock());
				end
			end else
				send_command(ail_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = ail_pkg::OP_ADD;
		start_ms = '0;
		end_ms = '0;
		clock_ms = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		error_count = 0;
		cmd_count = 0;
		stall_cycles = 0;
		sender_idle_pct = 0;
		entry_cnt = 0;
		hint_pos = 0;
		offset_model = '0;
		for (int i = 0; i < ail_pkg::DEPTH; i++) begin
			tab_start[i] = '0;
			tab_end[i] = '0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_bad_interval();
		test_hint_search();
		test_seek();
		test_offset_extremes();
		test_full_table();

		write_offset('0);
		test_random(300, 27);
		write_offset($urandom_range(0, 10000) - 5000);
		test_random(300, 65);
		write_offset($urandom);
		test_random(300, 0);

		drain_results(DRAIN_CYCLES);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ail_pkg.sv
src/ail_cell.sv
src/ail_ctrl.sv
src/active_interval_lookup.sv
bench/testbench.sv
